// File: src/i2csme_pkg.sv
// Shared types and constants for the I2C serial memory byte engine.
// Used by i2c_serial_memory_byte_engine; no dependencies.
`timescale 1ns / 1ps

package i2csme_pkg;

  localparam int SIZE_W = 17;
  localparam int PTR_W = 16;
  localparam int CNT_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int MEM_DEPTH_DEF = 65536;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd65536;
  localparam logic [SIZE_W-1:0] SMALL_SIZE_MAX = 17'd256;
  localparam logic [6:0] DEVICE_CODE_RESET = 7'd80;

  localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_CODE = 1'd1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_RX    = 2'd1,
    OP_TX    = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_ADDR_HI = 2'd0,
    PH_ADDR_LO = 2'd1,
    PH_DATA    = 2'd2,
    PH_STOPPED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MODULO,
    ST_ACCESS,
    ST_READ
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic [2:0] addr_pins;
  } cmd_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [6:0] slave_address;
  } res_t;

endpackage

// File: src/i2c_serial_memory_byte_engine.sv
// Byte engine of an I2C serial RAM: address pointer load, byte store and fetch.
// Depends on i2csme_pkg.
// Start, stop and address bytes give done the cycle after acceptance; a stored data
// byte passes the modulo and access states, a fetched byte also the read state. busy
// covers them, so one transaction is in flight at a time; the 16-step bit-serial
// pointer modulo and memory read add delay. done is a one-cycle strobe, not held off.
// Reset: synchronous; pointer 0, stopped phase, size 65536, device code 80; RAM not cleared.
`timescale 1ns / 1ps

module i2c_serial_memory_byte_engine #(
  parameter int MEM_DEPTH = i2csme_pkg::MEM_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  i2csme_pkg::cmd_t                 cmd,
  output logic                             done,
  output i2csme_pkg::res_t                 result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [i2csme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [i2csme_pkg::SIZE_W-1:0]    cfg_data
);

  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int SW = i2csme_pkg::SIZE_W;
  localparam int PW = i2csme_pkg::PTR_W;
  localparam int CW = i2csme_pkg::CNT_W;
  localparam logic [SW-1:0] DEPTH_SIZE = SW'(MEM_DEPTH);

  i2csme_pkg::state_t state, state_next;
  i2csme_pkg::phase_t phase;
  i2csme_pkg::op_t    op_q;
  i2csme_pkg::res_t   res;

  logic [PW-1:0]   pointer;
  logic [SW-1:0]   mem_size;
  logic [6:0]      device_code;
  logic [7:0]      data_q;
  logic [PW-1:0]   rem;
  logic [PW-1:0]   ptr_sh;
  logic [CW-1:0]   bit_cnt;
  logic [7:0]      rd_data;
  logic [7:0]      mem [MEM_DEPTH];
  logic            res_valid_q;

  logic [SW-1:0]   size_eff;
  logic            size_large;
  logic [SW-1:0]   rem_sh;
  logic [SW-1:0]   rem_step;
  logic [SW-1:0]   idx_inc;
  logic [PW-1:0]   ptr_adv;
  logic [AW-1:0]   mem_addr;
  logic            accept;
  logic            data_phase;
  logic            needs_mem;
  logic            mem_we;
  logic            mem_re;

  always_comb begin
    if (mem_size == '0) begin
      size_eff = SW'(1);
    end else if (mem_size > DEPTH_SIZE) begin
      size_eff = DEPTH_SIZE;
    end else begin
      size_eff = mem_size;
    end
  end

  assign size_large = size_eff > i2csme_pkg::SMALL_SIZE_MAX;
  assign data_phase = (phase == i2csme_pkg::PH_DATA) || (phase == i2csme_pkg::PH_STOPPED);
  assign accept = start && !busy;
  assign needs_mem = (cmd.op == i2csme_pkg::OP_TX) ||
                     ((cmd.op == i2csme_pkg::OP_RX) && data_phase);

  // restoring remainder step, one pointer bit per cycle
  assign rem_sh = {rem, ptr_sh[PW-1]};
  assign rem_step = (rem_sh >= size_eff) ? (rem_sh - size_eff) : rem_sh;

  assign idx_inc = {1'b0, rem} + SW'(1);
  assign ptr_adv = (idx_inc >= size_eff) ? '0 : idx_inc[PW-1:0];
  assign mem_addr = rem[AW-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      i2csme_pkg::ST_IDLE: begin
        if (accept && needs_mem) begin
          state_next = i2csme_pkg::ST_MODULO;
        end
      end
      i2csme_pkg::ST_MODULO: begin
        if (bit_cnt == '0) begin
          state_next = i2csme_pkg::ST_ACCESS;
        end
      end
      i2csme_pkg::ST_ACCESS: begin
        state_next = (op_q == i2csme_pkg::OP_TX) ? i2csme_pkg::ST_READ
                                                  : i2csme_pkg::ST_IDLE;
      end
      i2csme_pkg::ST_READ: begin
        state_next = i2csme_pkg::ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    busy = 1'b1;
    mem_we = 1'b0;
    mem_re = 1'b0;
    unique case (state)
      i2csme_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      i2csme_pkg::ST_MODULO: begin
        busy = 1'b1;
      end
      i2csme_pkg::ST_ACCESS: begin
        mem_we = (op_q == i2csme_pkg::OP_RX);
        mem_re = (op_q == i2csme_pkg::OP_TX);
      end
      i2csme_pkg::ST_READ: begin
        busy = 1'b1;
      end
    endcase
  end

  assign cfg_ready = !busy;
  assign done = res_valid_q;
  assign result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2csme_pkg::ST_IDLE;
      phase <= i2csme_pkg::PH_STOPPED;
      pointer <= '0;
      mem_size <= i2csme_pkg::SIZE_RESET;
      device_code <= i2csme_pkg::DEVICE_CODE_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state <= state_next;
      res_valid_q <= (accept && !needs_mem) ||
                     ((state == i2csme_pkg::ST_ACCESS) && (op_q == i2csme_pkg::OP_RX)) ||
                     (state == i2csme_pkg::ST_READ);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          i2csme_pkg::CFG_MEM_SIZE:    mem_size <= cfg_data;
          i2csme_pkg::CFG_DEVICE_CODE: device_code <= cfg_data[6:0];
        endcase
      end
      if (accept && !needs_mem) begin
        case (cmd.op)
          i2csme_pkg::OP_START: begin
            phase <= size_large ? i2csme_pkg::PH_ADDR_HI : i2csme_pkg::PH_ADDR_LO;
          end
          i2csme_pkg::OP_RX: begin
            if (phase == i2csme_pkg::PH_ADDR_HI) begin
              phase <= i2csme_pkg::PH_ADDR_LO;
              pointer <= {cmd.data_byte, 8'h00};
            end else begin
              phase <= i2csme_pkg::PH_DATA;
              pointer <= size_large ? (pointer + PW'(cmd.data_byte))
                                    : PW'(cmd.data_byte);
            end
          end
          default: begin
            phase <= i2csme_pkg::PH_STOPPED;
          end
        endcase
      end
      if (state == i2csme_pkg::ST_ACCESS) begin
        pointer <= ptr_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= cmd.op;
      data_q <= cmd.data_byte;
      rem <= '0;
      ptr_sh <= pointer;
      bit_cnt <= CW'(PW - 1);
      res.tx_byte <= '0;
      res.tx_valid <= 1'b0;
      res.slave_address <= device_code + {4'b0000, cmd.addr_pins};
    end else if (state == i2csme_pkg::ST_MODULO) begin
      rem <= rem_step[PW-1:0];
      ptr_sh <= {ptr_sh[PW-2:0], 1'b0};
      bit_cnt <= bit_cnt - CW'(1);
    end else if (state == i2csme_pkg::ST_READ) begin
      res.tx_byte <= rd_data;
      res.tx_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= data_q;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == i2csme_pkg::ST_IDLE))
    else $error("result strobe outside idle");

  a_tx_from_read: assert property (@(posedge clk) disable iff (rst)
    (done && result.tx_valid) |-> ($past(state) == i2csme_pkg::ST_READ))
    else $error("tx_valid without memory read");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == i2csme_pkg::ST_MODULO || state == i2csme_pkg::ST_ACCESS)
      |-> ({1'b0, rem} < size_eff))
    else $error("remainder not below size");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.op == i2csme_pkg::OP_TX) |=> (busy && !done))
    else $error("read transaction did not start");

endmodule
